// ===== rtl/tlpm_pkg.sv =====
// tick load percent monitor: shared widths, constants and types
// used by tlpm_ctrl, tlpm_datapath and tick_load_percent_monitor
`default_nettype none
package tlpm_pkg;

  localparam int TIMER_BITS   = 32;
  localparam int PERCENT_BITS = 16;
  localparam int SCALE_BITS   = 7;
  localparam int PROD_BITS    = TIMER_BITS + SCALE_BITS;
  localparam int CMP_BITS     = TIMER_BITS + PERCENT_BITS;
  localparam int CNT_BITS     = $clog2(PERCENT_BITS);
  localparam int THR_BITS     = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [SCALE_BITS-1:0]   PERCENT_SCALE = SCALE_BITS'(100);
  localparam logic [THR_BITS-1:0]     MAX_THR_RESET  = THR_BITS'(85);
  localparam logic [THR_BITS-1:0]     NEAR_THR_RESET = THR_BITS'(80);
  localparam logic [PERCENT_BITS-1:0] PERCENT_MAX    = {PERCENT_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]     LAST_STEP      = CNT_BITS'(PERCENT_BITS - 1);

  localparam logic ACTION_START   = 1'b0;
  localparam logic ACTION_MEASURE = 1'b1;

  localparam logic REG_MAX_THR  = 1'b0;
  localparam logic REG_NEAR_THR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic prep;
    logic step;
    logic commit;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic sat;
    logic last_step;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/tlpm_ctrl.sv =====
// tick load percent monitor: sequencing state machine
// depends on tlpm_pkg; drives tlpm_datapath through cmd_t, reads status_t
`default_nettype none
module tlpm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            action_i,
  input  wire tlpm_pkg::status_t status_i,
  output tlpm_pkg::cmd_t       cmd_o,
  output logic                 in_stall_o
);
  import tlpm_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (action_i == ACTION_MEASURE) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:    state_d = ST_PREP;
      ST_PREP:   state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.sat || status_i.last_step) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = accept;
      end
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_PREP:   cmd_o.prep = 1'b1;
      ST_DIV:    cmd_o.step = !status_i.sat;
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_DONE:   cmd_o.deliver = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tlpm_datapath.sv =====
// tick load percent monitor: period state, product, restoring divider,
// peak tracking and output register; depends on tlpm_pkg, driven by tlpm_ctrl
`default_nettype none
module tlpm_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tlpm_pkg::cmd_t                     cmd_i,
  output tlpm_pkg::status_t                       status_o,
  input  wire logic                               action_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    start_ticks_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    period_ticks_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    ticks_left_i,
  input  wire logic [tlpm_pkg::THR_BITS-1:0]      max_thr_i,
  input  wire logic [tlpm_pkg::THR_BITS-1:0]      near_thr_i,
  input  wire logic                               out_stall_i,
  output logic                                    out_valid_o,
  output logic [tlpm_pkg::PERCENT_BITS-1:0]       load_percent_o,
  output logic [tlpm_pkg::PERCENT_BITS-1:0]       peak_percent_o,
  output logic                                    at_max_o,
  output logic                                    near_max_o
);
  import tlpm_pkg::*;

  logic [TIMER_BITS-1:0]   start_q, period_q, left_q;
  logic [PROD_BITS-1:0]    product_q;
  logic [TIMER_BITS-1:0]   rem_q, rem_d;
  logic [PERCENT_BITS-1:0] quot_q, quot_d;
  logic [PERCENT_BITS-1:0] lo_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic                    sat_q, sat_d;
  logic [PERCENT_BITS-1:0] cur_q, cur_d, peak_q, peak_d;
  logic                    out_valid_q;
  logic [PERCENT_BITS-1:0] out_load_q, out_peak_q;
  logic                    out_at_q, out_near_q;

  logic [TIMER_BITS-1:0]   elapsed;
  logic [TIMER_BITS:0]     trial;
  logic                    fits;
  logic [THR_BITS-1:0]     cur_thr;

  assign elapsed = start_q - left_q;
  assign trial   = {rem_q, lo_q[PERCENT_BITS-1]};
  assign fits    = trial >= {1'b0, period_q};
  assign cur_thr = THR_BITS'(cur_q);

  // overflow of the 16-bit quotient is known before dividing
  always_comb begin
    sat_d = (period_q == '0) ||
            ({(CMP_BITS - PROD_BITS)'(0), product_q} >= {period_q, PERCENT_BITS'(0)});
  end

  always_comb begin
    rem_d  = fits ? TIMER_BITS'(trial - {1'b0, period_q}) : trial[TIMER_BITS-1:0];
    quot_d = {quot_q[PERCENT_BITS-2:0], fits};
  end

  always_comb begin
    cur_d  = sat_q ? PERCENT_MAX : quot_q;
    peak_d = (cur_d > peak_q) ? cur_d : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      period_q <= '0;
      cur_q    <= '0;
      peak_q   <= '0;
    end else if (cmd_i.accept && (action_i == ACTION_START)) begin
      start_q  <= start_ticks_i;
      period_q <= period_ticks_i;
      cur_q    <= '0;
      peak_q   <= '0;
    end else if (cmd_i.commit) begin
      cur_q    <= cur_d;
      peak_q   <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      left_q <= ticks_left_i;
    end
    if (cmd_i.mul) begin
      product_q <= PROD_BITS'(elapsed) * PROD_BITS'(PERCENT_SCALE);
    end
    if (cmd_i.prep) begin
      rem_q  <= TIMER_BITS'(product_q >> PERCENT_BITS);
      lo_q   <= product_q[PERCENT_BITS-1:0];
      quot_q <= '0;
      sat_q  <= sat_d;
    end else if (cmd_i.step) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[PERCENT_BITS-2:0], 1'b0};
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_BITS'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      out_load_q <= cur_q;
      out_peak_q <= peak_q;
      out_at_q   <= cur_thr >= max_thr_i;
      out_near_q <= (cur_thr >= near_thr_i) && (cur_thr < max_thr_i);
    end
  end

  assign status_o.sat       = sat_q;
  assign status_o.last_step = (cnt_q == LAST_STEP);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign load_percent_o = out_load_q;
  assign peak_percent_o = out_peak_q;
  assign at_max_o       = out_at_q;
  assign near_max_o     = out_near_q;

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rem_q < period_q))
    else $error("divider remainder not below period");

  a_peak_ge_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= cur_q)
    else $error("peak below current load");

  a_deliver_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deliver |=> out_valid_q)
    else $error("delivered result not valid");

endmodule
`default_nettype wire

// ===== rtl/tick_load_percent_monitor.sv =====
// tick load percent monitor top level: APB threshold registers and glue
// depends on tlpm_pkg, tlpm_ctrl and tlpm_datapath
//
// Usage: the input channel (in_valid_i/in_stall_o) carries one request per
// item. action_i = 0 starts a period (start_ticks_i, period_ticks_i latched,
// current and peak load cleared); action_i = 1 measures with ticks_left_i.
// Every request yields exactly one result on the output channel
// (out_valid_o/out_stall_i): load_percent_o, peak_percent_o, at_max_o,
// near_max_o. Thresholds are written over the APB port (max at 0x0, near at
// 0x4); the user must write them only while the block is idle, which the
// block itself does not enforce. A start request goes straight to its
// result. A measurement passes through the x100 multiply, the overflow
// check and the one-bit-per-cycle restoring divider, then commits its load
// and peak; one that saturates (zero period or quotient above 65535) skips
// the divider steps. One request is worked on at a time; the next is
// accepted while a finished result still sits in the output register. If
// the receiver stalls, the result holds and a new result waits in the
// sequencer until it is taken. Reset clears the period state, loads and
// output valid; thresholds return to 85 and 80.
`default_nettype none
module tick_load_percent_monitor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               action_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    start_ticks_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    period_ticks_i,
  input  wire logic [tlpm_pkg::TIMER_BITS-1:0]    ticks_left_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [tlpm_pkg::PERCENT_BITS-1:0]       load_percent_o,
  output logic [tlpm_pkg::PERCENT_BITS-1:0]       peak_percent_o,
  output logic                                    at_max_o,
  output logic                                    near_max_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tlpm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [tlpm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tlpm_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                    pready
);
  import tlpm_pkg::*;

  logic [THR_BITS-1:0] max_thr_q, near_thr_q;
  logic                wr_en;
  logic                reg_sel;
  cmd_t                cmd;
  status_t             status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_thr_q  <= MAX_THR_RESET;
      near_thr_q <= NEAR_THR_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_THR:  max_thr_q  <= pwdata[THR_BITS-1:0];
        REG_NEAR_THR: near_thr_q <= pwdata[THR_BITS-1:0];
        default:      max_thr_q  <= max_thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_THR:  prdata = APB_DATA_BITS'(max_thr_q);
      REG_NEAR_THR: prdata = APB_DATA_BITS'(near_thr_q);
      default:      prdata = '0;
    endcase
  end

  tlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  tlpm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .start_ticks_i  (start_ticks_i),
    .period_ticks_i (period_ticks_i),
    .ticks_left_i   (ticks_left_i),
    .max_thr_i      (max_thr_q),
    .near_thr_i     (near_thr_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .load_percent_o (load_percent_o),
    .peak_percent_o (peak_percent_o),
    .at_max_o       (at_max_o),
    .near_max_o     (near_max_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tick_load_percent_monitor_tb.sv =====
// testbench for tick_load_percent_monitor: directed and random requests with
// bursty sender, random receiver stalls and apb threshold writes
// depends on tlpm_pkg and the tick_load_percent_monitor rtl
`timescale 1ns / 100ps

module tick_load_percent_monitor_tb;
  import tlpm_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_SETTLE = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [PERCENT_BITS-1:0] load;
    logic [PERCENT_BITS-1:0] peak;
    logic                    at_max;
    logic                    near_max;
  } load_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     action_i = ACTION_START;
  logic [TIMER_BITS-1:0]    start_ticks_i = '0;
  logic [TIMER_BITS-1:0]    period_ticks_i = '0;
  logic [TIMER_BITS-1:0]    ticks_left_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PERCENT_BITS-1:0]  load_percent_o;
  logic [PERCENT_BITS-1:0]  peak_percent_o;
  logic                     at_max_o;
  logic                     near_max_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // load predictor state and thresholds
  logic [TIMER_BITS-1:0]   pm_start = '0;
  logic [TIMER_BITS-1:0]   pm_period = '0;
  logic [PERCENT_BITS-1:0] pm_load = '0;
  logic [PERCENT_BITS-1:0] pm_peak = '0;
  logic [THR_BITS-1:0]     thr_max = MAX_THR_RESET;
  logic [THR_BITS-1:0]     thr_near = NEAR_THR_RESET;

  load_result_t load_results_q[$];

  int n_errors = 0;
  int n_requests = 0;
  int n_starts = 0;
  int n_saturated = 0;
  int n_settings = 0;
  int n_results = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  tick_load_percent_monitor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .start_ticks_i  (start_ticks_i),
    .period_ticks_i (period_ticks_i),
    .ticks_left_i   (ticks_left_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .load_percent_o (load_percent_o),
    .peak_percent_o (peak_percent_o),
    .at_max_o       (at_max_o),
    .near_max_o     (near_max_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [PERCENT_BITS-1:0] calc_load(
    input logic [TIMER_BITS-1:0] elapsed,
    input logic [TIMER_BITS-1:0] period
  );
    logic [63:0] quot;
    if (period == '0) return PERCENT_MAX;
    quot = ({32'b0, elapsed} * 64'd100) / {32'b0, period};
    if (quot > {48'b0, PERCENT_MAX}) return PERCENT_MAX;
    return quot[PERCENT_BITS-1:0];
  endfunction

  task automatic predict_request(
    input logic act,
    input logic [TIMER_BITS-1:0] st,
    input logic [TIMER_BITS-1:0] pr,
    input logic [TIMER_BITS-1:0] lf
  );
    load_result_t r;
    if (act == ACTION_START) begin
      pm_start = st;
      pm_period = pr;
      pm_load = '0;
      pm_peak = '0;
      n_starts++;
    end else begin
      pm_load = calc_load(pm_start - lf, pm_period);
      if (pm_load > pm_peak) pm_peak = pm_load;
      if (pm_load == PERCENT_MAX) n_saturated++;
    end
    r.load = pm_load;
    r.peak = pm_peak;
    r.at_max = (pm_load >= thr_max);
    r.near_max = (pm_load >= thr_near) && (pm_load < thr_max);
    load_results_q.push_back(r);
    n_requests++;
  endtask

  // drives one request at the current edge and returns at the accepting edge
  task automatic send_request(
    input logic act,
    input logic [TIMER_BITS-1:0] st,
    input logic [TIMER_BITS-1:0] pr,
    input logic [TIMER_BITS-1:0] lf
  );
    in_valid_i <= 1'b1;
    action_i <= act;
    start_ticks_i <= st;
    period_ticks_i <= pr;
    ticks_left_i <= lf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(act, st, pr, lf);
  endtask

  // sender bursts: random gap between bursts of random length
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic offer(
    input logic act,
    input logic [TIMER_BITS-1:0] st,
    input logic [TIMER_BITS-1:0] pr,
    input logic [TIMER_BITS-1:0] lf
  );
    pace();
    send_request(act, st, pr, lf);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (load_results_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic idx, input logic [THR_BITS-1:0] val);
    logic [15:0] upper;
    upper = 16'($urandom_range(0, 65535));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {upper, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_THR) thr_max = val;
    else thr_near = val;
  endtask

  task automatic set_thresholds(
    input logic [THR_BITS-1:0] max_v,
    input logic [THR_BITS-1:0] near_v
  );
    wait_idle();
    write_threshold(REG_MAX_THR, max_v);
    write_threshold(REG_NEAR_THR, near_v);
    n_settings++;
  endtask

  // a start request followed by measurements spread around the thresholds,
  // with some broken sequences and plain noise mixed in
  task automatic run_sequences(input int n_items);
    int sent;
    int k;
    int pct;
    logic [TIMER_BITS-1:0] st;
    logic [TIMER_BITS-1:0] pr;
    logic [63:0] span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        offer(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        sent++;
      end else begin
        st = $urandom;
        case ($urandom_range(0, 9))
          0: pr = '0;
          1: pr = TIMER_BITS'($urandom_range(1, 8));
          2: pr = $urandom;
          default: pr = TIMER_BITS'($urandom_range(50, 200000));
        endcase
        offer(ACTION_START, st, pr, $urandom);
        sent++;
        k = $urandom_range(1, 8);
        repeat (k) begin
          if ($urandom_range(0, 1) == 0) pct = $urandom_range(70, 95);
          else pct = $urandom_range(0, 200);
          span = ({32'b0, pr} * pct) / 100 + $urandom_range(0, 3);
          if ($urandom_range(0, 19) == 0) offer(ACTION_MEASURE, $urandom, $urandom, $urandom);
          else offer(ACTION_MEASURE, $urandom, $urandom, st - span[TIMER_BITS-1:0]);
          sent++;
        end
      end
    end
  endtask

  task automatic test_measure_before_start();
    offer(ACTION_MEASURE, '0, '0, '0);
    offer(ACTION_MEASURE, '1, '1, '1);
  endtask

  task automatic test_start_at_zero_threshold();
    set_thresholds('0, '0);
    offer(ACTION_START, $urandom, $urandom, $urandom);
    offer(ACTION_MEASURE, $urandom, $urandom, $urandom);
    set_thresholds(MAX_THR_RESET, NEAR_THR_RESET);
  endtask

  task automatic test_load_extremes();
    offer(ACTION_START, '1, '1, '0);
    offer(ACTION_MEASURE, '0, '0, '0);
    offer(ACTION_MEASURE, '0, '0, '1);
    // boundaries of the default thresholds
    offer(ACTION_START, 32'd100, 32'd100, '0);
    offer(ACTION_MEASURE, '0, '0, 32'd16);
    offer(ACTION_MEASURE, '0, '0, 32'd15);
    offer(ACTION_MEASURE, '0, '0, 32'd20);
    offer(ACTION_MEASURE, '0, '0, 32'd21);
    offer(ACTION_MEASURE, '0, '0, '0);
    // timer wrap
    offer(ACTION_START, 32'd100, 32'd1000, '0);
    offer(ACTION_MEASURE, '0, '0, 32'hFFFF_FF00);
    // largest load that fits and the first that saturates
    offer(ACTION_START, 32'd65535, 32'd100, '0);
    offer(ACTION_MEASURE, '0, '0, '0);
    offer(ACTION_START, 32'd65536, 32'd100, '0);
    offer(ACTION_MEASURE, '0, '0, '0);
    offer(ACTION_START, '0, 32'd1, '0);
    offer(ACTION_MEASURE, '0, '0, '0);
    offer(ACTION_MEASURE, '0, '0, 32'd1);
    // zero period
    offer(ACTION_START, 32'd5, '0, '0);
    offer(ACTION_MEASURE, '0, '0, 32'd3);
  endtask

  task automatic test_threshold_settings();
    set_thresholds('1, '1);
    run_sequences(100);
    set_thresholds(16'd50, 16'd90);
    run_sequences(100);
    set_thresholds(16'd100, '0);
    run_sequences(100);
    set_thresholds('0, '1);
    run_sequences(60);
    repeat (2) begin
      set_thresholds(THR_BITS'($urandom_range(0, 150)), THR_BITS'($urandom_range(0, 150)));
      run_sequences(100);
    end
    set_thresholds(MAX_THR_RESET, NEAR_THR_RESET);
  endtask

  task automatic test_random_sequences();
    run_sequences(280);
  endtask

  task automatic test_output_backpressure();
    logic [TIMER_BITS-1:0] st;
    st = $urandom;
    hold_req = 1'b1;
    send_request(ACTION_START, st, 32'd1000, '0);
    repeat (30) send_request(ACTION_MEASURE, '0, '0, st - $urandom_range(0, 1200));
  endtask

  // receiver stall pattern with a long hold when hold_req is set
  always @(posedge clk_i) begin : stall_pattern
    static int seg_left = 0;
    static int stall_pct = 0;
    static int hold_left = 0;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    load_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (load_results_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual load %0d peak %0d",
                 $time, load_percent_o, peak_percent_o);
        n_errors++;
      end else begin
        exp_r = load_results_q.pop_front();
        if (load_percent_o !== exp_r.load) begin
          $display("%0t: load_percent expected %0d actual %0d", $time, exp_r.load, load_percent_o);
          n_errors++;
        end
        if (peak_percent_o !== exp_r.peak) begin
          $display("%0t: peak_percent expected %0d actual %0d", $time, exp_r.peak, peak_percent_o);
          n_errors++;
        end
        if (at_max_o !== exp_r.at_max) begin
          $display("%0t: at_max expected %0b actual %0b", $time, exp_r.at_max, at_max_o);
          n_errors++;
        end
        if (near_max_o !== exp_r.near_max) begin
          $display("%0t: near_max expected %0b actual %0b", $time, exp_r.near_max, near_max_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, load_results_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_measure_before_start();
    test_start_at_zero_threshold();
    test_load_extremes();
    test_output_backpressure();
    test_threshold_settings();
    test_random_sequences();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (%0d starts), %0d saturated loads, %0d threshold settings",
             n_requests, n_starts, n_saturated, n_settings);
    $display("%0d results compared, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
